[src/sth_pkg.sv]
// ----------------------------------------------------------------------------
// sth_pkg: shared types and constants of the sleep timer heap
// Operation and status codes, transaction payloads, front-to-back command.
// ----------------------------------------------------------------------------
package sth_pkg;

    localparam int CAPACITY_DEF = 32;
    localparam int TID_W = 5;
    localparam int NUM_THREADS = 32;
    localparam int TIME_W = 64;
    localparam int CNT_W = 6;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_TICK   = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_ADDED    = 3'd0,
        ST_REMOVED  = 3'd1,
        ST_EXPIRED  = 3'd2,
        ST_NONE_DUE = 3'd3,
        ST_FULL     = 3'd4,
        ST_NOT_Q    = 3'd5,
        ST_ALREADY  = 3'd6
    } t_status;

    typedef struct packed {
        logic [1:0]        operation;
        logic [TID_W-1:0]  thread_id;
        logic [TIME_W-1:0] timeout;
        logic [TIME_W-1:0] now;
    } t_in;

    typedef struct packed {
        logic [2:0]        status;
        logic [TID_W-1:0]  thread_id_res;
        logic [TIME_W-1:0] due_time;
        logic [CNT_W-1:0]  queue_count;
        logic              last;
    } t_out;

    typedef struct packed {
        t_op               op;
        logic [TID_W-1:0]  tid;
        logic [TIME_W-1:0] val;
    } t_cmd;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_RES_RD,
        S_UP_RD,
        S_UP_CMP,
        S_TAKE_RD,
        S_TAKE_WR,
        S_DN_RD,
        S_DN_RD2,
        S_DN_CMP,
        S_PLACE,
        S_TICK_RD,
        S_TICK_CMP,
        S_EMIT
    } t_state;

endpackage

[src/sleep_timer_min_heap.sv]
// ----------------------------------------------------------------------------
// sleep_timer_min_heap: timer queue of sleeping threads on a binary min-heap
// Add, remove and tick run on a heap memory behind a two-entry command queue.
// ----------------------------------------------------------------------------
//  channel | signals                        | payload
//  in      | i_valid, o_stall               | t_in: operation, thread_id, timeout, now
//  out     | o_valid, i_stall               | t_out: status, thread_id_res, due_time, ...
//  Going up, each heap level takes a read and a compare step; going down, a read
//  of the left child, a read of the right child and a compare step. The heap
//  memory has one registered read port and one write port.
//  Reset clears the thread slot table, count and clock; no clearing pass.
//  A stalled result holds the engine; the input queue keeps taking two items.
// ----------------------------------------------------------------------------
module sleep_timer_min_heap #(
    parameter int CAPACITY = sth_pkg::CAPACITY_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  sth_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_stall,
    output sth_pkg::t_out o_data
);
    import sth_pkg::*;

    logic w_cv, w_pop;
    t_cmd w_cmd;

    sth_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_data,
        .o_cmd_valid(w_cv), .i_cmd_pop(w_pop), .o_cmd(w_cmd)
    );

    sth_back #(.CAPACITY(CAPACITY)) u_back (
        .i_clk, .i_rst_n, .i_cmd_valid(w_cv), .o_cmd_pop(w_pop), .i_cmd(w_cmd),
        .o_valid, .i_stall, .o_data
    );

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("result dropped while stalled");
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_data.queue_count <= 6'(CAPACITY))
        else $error("queue count above capacity");
    a_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_cv)
        else $error("pop from empty command queue");

endmodule

[src/sth_front.sv]
// ----------------------------------------------------------------------------
// sth_front: input stage and command queue
// Drops undefined operations and queues commands for the heap engine.
// ----------------------------------------------------------------------------
module sth_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  sth_pkg::t_in  i_data,
    output logic          o_cmd_valid,
    input  logic          i_cmd_pop,
    output sth_pkg::t_cmd o_cmd
);
    import sth_pkg::*;

    t_cmd       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    t_cmd       w_cmd;
    logic       w_push;

    always_comb begin
        w_cmd.op  = t_op'(i_data.operation);
        w_cmd.tid = i_data.thread_id;
        w_cmd.val = (i_data.operation == OP_TICK) ? i_data.now : i_data.timeout;
    end

    assign o_stall     = (r_cnt == 2'd2);
    assign w_push      = i_valid && !o_stall && (w_cmd.op != OP_NONE);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (i_cmd_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(w_push) - 2'(i_cmd_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_q[r_wp] <= w_cmd;
    end

endmodule

[src/sth_back.sv]
// ----------------------------------------------------------------------------
// sth_back: heap engine
// Runs add, remove and tick on the heap memory, one heap level at a time.
// ----------------------------------------------------------------------------
module sth_back #(
    parameter int CAPACITY = sth_pkg::CAPACITY_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_valid,
    output logic          o_cmd_pop,
    input  sth_pkg::t_cmd i_cmd,
    output logic          o_valid,
    input  logic          i_stall,
    output sth_pkg::t_out o_data
);
    import sth_pkg::*;

    localparam int SW = $clog2(CAPACITY + 1) + 1;
    localparam int AW = $clog2(CAPACITY + 1);

    logic [TIME_W-1:0] m_due [CAPACITY+1];
    logic [TID_W-1:0]  m_tid [CAPACITY+1];
    logic [SW-1:0]     r_slot [NUM_THREADS];

    t_state            r_st, n_st;
    t_cmd              r_cmd;
    logic [SW-1:0]     r_cnt;
    logic [TIME_W-1:0] r_clk;
    logic [SW-1:0]     r_s;
    logic [TIME_W-1:0] r_due;
    logic [TID_W-1:0]  r_tid;
    logic [TIME_W-1:0] r_rd_due, r_l_due;
    logic [TID_W-1:0]  r_rd_tid, r_l_tid;
    logic [TIME_W-1:0] r_res_due;
    logic [TID_W-1:0]  r_res_tid;
    t_status           r_res_st;
    logic              r_emitted, r_res_last, r_down;
    logic              r_ov;
    t_out              r_out;

    logic [SW-1:0]     w_ra;
    logic              w_we;
    logic [SW-1:0]     w_wa;
    logic [TIME_W-1:0] w_wdue;
    logic [TID_W-1:0]  w_wtid;
    logic              w_sw;
    logic [TID_W-1:0]  w_sa;
    logic [SW-1:0]     w_sv;
    logic [SW-1:0]     w_qs;
    logic              w_queued;
    logic              w_full;
    logic              w_is_tick;
    logic [SW-1:0]     w_l, w_r;
    logic              w_right;
    logic [TIME_W-1:0] w_ydue;
    logic [TID_W-1:0]  w_ytid;
    logic              w_due_ok;
    logic              w_load;

    assign w_qs      = r_slot[r_cmd.tid];
    assign w_queued  = (w_qs != '0) && (w_qs <= r_cnt);
    assign w_full    = (r_cnt >= SW'(CAPACITY));
    assign w_is_tick = (r_cmd.op == OP_TICK);
    assign w_l       = {r_s[SW-2:0], 1'b0};
    assign w_r       = {r_s[SW-2:0], 1'b1};
    assign w_right   = (w_r <= r_cnt) && !(r_l_due < r_rd_due);
    assign w_ydue    = w_right ? r_rd_due : r_l_due;
    assign w_ytid    = w_right ? r_rd_tid : r_l_tid;
    assign w_due_ok  = (r_rd_due <= r_cmd.val);
    assign w_load    = (r_st == S_EMIT) && !(r_ov && i_stall);
    assign o_cmd_pop = (r_st == S_IDLE) && i_cmd_valid;
    assign o_valid   = r_ov;
    assign o_data    = r_out;

    always_ff @(posedge i_clk) begin
        r_rd_due <= m_due[w_ra[AW-1:0]];
        r_rd_tid <= m_tid[w_ra[AW-1:0]];
        if (w_we) begin
            m_due[w_wa[AW-1:0]] <= w_wdue;
            m_tid[w_wa[AW-1:0]] <= w_wtid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_THREADS; i++) r_slot[i] <= '0;
        end else if (w_sw) begin
            r_slot[w_sa] <= w_sv;
        end
    end

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            S_IDLE:     if (i_cmd_valid) n_st = S_CHECK;
            S_CHECK: begin
                unique case (r_cmd.op)
                    OP_ADD:    n_st = w_queued ? S_RES_RD : (w_full ? S_EMIT : S_UP_RD);
                    OP_REMOVE: n_st = w_queued ? S_RES_RD : S_EMIT;
                    default:   n_st = S_TICK_RD;
                endcase
            end
            S_RES_RD:   n_st = (r_cmd.op == OP_ADD) ? S_EMIT : S_TAKE_RD;
            S_TAKE_RD:  n_st = S_TAKE_WR;
            S_TAKE_WR:  n_st = (r_s != r_cnt) ? S_UP_RD : (w_is_tick ? S_TICK_RD : S_EMIT);
            S_UP_RD:    n_st = (r_s > SW'(1)) ? S_UP_CMP : (r_down ? S_DN_RD : S_PLACE);
            S_UP_CMP:   n_st = (r_due < r_rd_due) ? S_UP_RD : (r_down ? S_DN_RD : S_PLACE);
            S_DN_RD:    n_st = (w_l > r_cnt) ? S_PLACE : S_DN_RD2;
            S_DN_RD2:   n_st = S_DN_CMP;
            S_DN_CMP:   n_st = (r_due > w_ydue) ? S_DN_RD : S_PLACE;
            S_PLACE:    n_st = w_is_tick ? S_TICK_RD : S_EMIT;
            S_TICK_RD:  n_st = (r_cnt == '0) ? S_EMIT : S_TICK_CMP;
            S_TICK_CMP: n_st = (!w_due_ok || r_emitted) ? S_EMIT : S_TAKE_RD;
            S_EMIT:     if (w_load) n_st = r_res_last ? S_IDLE : S_TICK_RD;
            default:    n_st = S_IDLE;
        endcase
    end

    always_comb begin
        w_ra = r_s;
        w_we = 1'b0; w_wa = r_s; w_wdue = r_due; w_wtid = r_tid;
        w_sw = 1'b0; w_sa = r_tid; w_sv = r_s;
        unique case (r_st)
            S_CHECK: begin
                w_ra = w_qs;
                if (r_cmd.op == OP_REMOVE && w_queued) begin
                    w_sw = 1'b1; w_sa = r_cmd.tid; w_sv = '0;
                end
            end
            S_TAKE_RD: w_ra = r_cnt;
            S_UP_RD:   w_ra = r_s >> 1;
            S_UP_CMP: if (r_due < r_rd_due) begin
                w_we = 1'b1; w_wdue = r_rd_due; w_wtid = r_rd_tid;
                w_sw = 1'b1; w_sa = r_rd_tid;
            end
            S_DN_RD:   w_ra = w_l;
            S_DN_RD2:  w_ra = w_r;
            S_DN_CMP: if (r_due > w_ydue) begin
                w_we = 1'b1; w_wdue = w_ydue; w_wtid = w_ytid;
                w_sw = 1'b1; w_sa = w_ytid;
            end
            S_PLACE: begin
                w_we = 1'b1;
                w_sw = 1'b1;
            end
            S_TICK_RD: w_ra = SW'(1);
            S_TICK_CMP: if (w_due_ok && !r_emitted) begin
                w_sw = 1'b1; w_sa = r_rd_tid; w_sv = '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_cnt <= '0;
            r_clk <= '0;
            r_ov <= 1'b0;
            r_emitted <= 1'b0;
        end else begin
            r_st <= n_st;
            r_ov <= w_load || (r_ov && i_stall);
            unique case (r_st)
                S_IDLE: if (i_cmd_valid) r_cmd <= i_cmd;
                S_CHECK: begin
                    r_res_last <= 1'b1;
                    r_emitted <= 1'b0;
                    unique case (r_cmd.op)
                        OP_ADD: begin
                            r_down <= 1'b0;
                            r_res_tid <= r_cmd.tid;
                            if (w_queued) begin
                                r_res_st <= ST_ALREADY;
                                r_res_due <= '0;
                            end else if (w_full) begin
                                r_res_st <= ST_FULL;
                                r_res_due <= '0;
                            end else begin
                                r_res_st <= ST_ADDED;
                                r_due <= r_clk + r_cmd.val;
                                r_res_due <= r_clk + r_cmd.val;
                                r_tid <= r_cmd.tid;
                                r_cnt <= r_cnt + SW'(1);
                                r_s <= r_cnt + SW'(1);
                            end
                        end
                        OP_REMOVE: begin
                            r_res_tid <= r_cmd.tid;
                            r_res_due <= '0;
                            if (w_queued) begin
                                r_res_st <= ST_REMOVED;
                                r_s <= w_qs;
                            end else begin
                                r_res_st <= ST_NOT_Q;
                            end
                        end
                        default: begin
                            r_clk <= r_cmd.val;
                            r_res_st <= ST_NONE_DUE;
                            r_res_tid <= '0;
                            r_res_due <= '0;
                        end
                    endcase
                end
                S_RES_RD: r_res_due <= r_rd_due;
                S_TAKE_WR: begin
                    r_cnt <= r_cnt - SW'(1);
                    r_due <= r_rd_due;
                    r_tid <= r_rd_tid;
                    r_down <= 1'b1;
                end
                S_UP_CMP: if (r_due < r_rd_due) r_s <= r_s >> 1;
                S_DN_RD2: begin
                    r_l_due <= r_rd_due;
                    r_l_tid <= r_rd_tid;
                end
                S_DN_CMP: if (r_due > w_ydue) r_s <= {r_s[SW-2:0], w_right};
                S_TICK_RD: if (r_cnt == '0) r_res_last <= 1'b1;
                S_TICK_CMP: begin
                    if (!w_due_ok) begin
                        r_res_last <= 1'b1;
                    end else if (r_emitted) begin
                        r_res_last <= 1'b0;
                    end else begin
                        r_emitted <= 1'b1;
                        r_res_st <= ST_EXPIRED;
                        r_res_tid <= r_rd_tid;
                        r_res_due <= r_rd_due;
                        r_s <= SW'(1);
                    end
                end
                S_EMIT: if (w_load) begin
                    r_emitted <= 1'b0;
                    r_out <= '{status: r_res_st, thread_id_res: r_res_tid,
                               due_time: r_res_due, queue_count: CNT_W'(r_cnt),
                               last: r_res_last};
                end
                default: ;
            endcase
        end
    end

endmodule
